>>> rtl/tsdx_pkg.sv
`timescale 1ns / 1ps
package tsdx_pkg;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DELTA    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_UNUSED   = 2'd3
    } status_e_t;

    localparam logic [63:0] FIRST_DELTA_MAX = 64'd16383;
    localparam logic [7:0]  HEADER_BITS     = 8'd96;
    localparam int          CODE_W          = 128;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] timestamp;
        logic [63:0] value_bits;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_word;
        logic        word_valid;
        logic        last;
        logic [1:0]  status;
        logic [31:0] point_count;
        logic [34:0] bit_length;
    } out_item_t;

    typedef struct packed {
        logic [63:0] block_start_time;
        logic [31:0] capacity_bytes;
    } cfg_t;

    // One classified item handed from front to back.
    typedef struct packed {
        logic              restart;
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [7:0]        len;
        logic [1:0]        status;
        logic [31:0]       count;
        logic [34:0]       bits;
    } entry_t;

endpackage

>>> rtl/time_series_delta_xor_encoder.sv
`timescale 1ns / 1ps
// Delta-of-delta / XOR time series encoder. Items on s_ carry a request (start, sample,
// finish); results on m_ carry finished 64-bit stream words, MSB first, with status,
// point count and bit length. The front stage takes no new item into its second stage
// until the last one has left it: the encoder state (previous time, delta, value, XOR
// window, bit count) is committed by the second front stage and the next item's deltas
// are formed only from it. A short queue sits between the front and the word packer,
// so the front keeps working while results wait on m_ready. A sample whose code crosses
// a word boundary twice yields two results. Registers: block_start_time at 0x0,
// capacity_bytes at 0x8 (64-bit APB data); write them only while the block is idle.
module time_series_delta_xor_encoder
    import tsdx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic CFG_BLOCK_TIME = 1'b0;
    localparam logic CFG_CAPACITY   = 1'b1;

    cfg_t   cfg_reg;
    logic   q_full, q_push, q_pop, q_valid;
    entry_t q_in, q_head;

    // Registers decode on paddr[3] only; block_start_time is 8 bytes wide, capacity_bytes 4.
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3])
            CFG_BLOCK_TIME: prdata = cfg_reg.block_start_time;
            default:        prdata = {32'b0, cfg_reg.capacity_bytes};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_start_time <= '0;
            cfg_reg.capacity_bytes   <= 32'hFFFF_FFFF;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == CFG_CAPACITY)
                cfg_reg.capacity_bytes <= pwdata[31:0];
            else
                cfg_reg.block_start_time <= pwdata;
        end
    end

    // Front: classify, encode, capacity check, state commit.
    tsdx_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    tsdx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Back: bit packing into words and result delivery.
    tsdx_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/tsdx_front.sv
`timescale 1ns / 1ps
module tsdx_front
    import tsdx_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     q_push,
    output entry_t   q_entry
);

    function automatic logic [5:0] clz64(input logic [63:0] v);
        logic [63:0] t;
        logic [5:0]  n;
        begin
            t = v;
            n = '0;
            if (t[63:32] == '0) begin n[5] = 1'b1; t = {t[31:0], 32'b0}; end
            if (t[63:48] == '0) begin n[4] = 1'b1; t = {t[47:0], 16'b0}; end
            if (t[63:56] == '0) begin n[3] = 1'b1; t = {t[55:0], 8'b0}; end
            if (t[63:60] == '0) begin n[2] = 1'b1; t = {t[59:0], 4'b0}; end
            if (t[63:62] == '0) begin n[1] = 1'b1; t = {t[61:0], 2'b0}; end
            if (!t[63]) n[0] = 1'b1;
            return n;
        end
    endfunction

    function automatic logic [63:0] rev64(input logic [63:0] v);
        logic [63:0] r;
        begin
            for (int i = 0; i < 64; i++) r[i] = v[63-i];
            return r;
        end
    endfunction

    // stage A: input register
    logic     a_valid_reg, a_valid_next;
    in_item_t a_reg;

    // stage B: deltas, xor, zero counts
    logic        b_valid_reg, b_valid_next;
    logic [1:0]  b_req_reg;
    logic [63:0] b_ts_reg, b_v_reg, b_delta_reg, b_dod_reg, b_x_reg, b_xwin_reg;
    logic        b_xzero_reg;
    logic [4:0]  b_ld_reg;
    logic [5:0]  b_tr_reg;

    // encoder state
    logic [63:0] prev_time_reg, prev_time_next;
    logic [63:0] prev_delta_reg, prev_delta_next;
    logic [63:0] prev_value_reg, prev_value_next;
    logic [5:0]  wl_reg, wl_next;
    logic [6:0]  wt_reg, wt_next;
    logic        first_reg, first_next;
    logic [31:0] count_reg, count_next;
    logic [34:0] bits_reg, bits_next;

    logic a_adv;
    assign a_adv   = a_valid_reg && !b_valid_reg;
    assign s_ready = !a_valid_reg || a_adv;

    logic [63:0] x_a;
    logic [5:0]  lz_a, tz_a;
    assign x_a  = prev_value_reg ^ a_reg.value_bits;
    assign lz_a = clz64(x_a);
    assign tz_a = clz64(rev64(x_a));

    // code build from stage B
    logic [35:0]       tcode;
    logic [7:0]        tlen;
    logic [76:0]       vcode;
    logic [7:0]        vlen;
    logic [CODE_W-1:0] scode;
    logic [7:0]        slen;
    logic              in_win;
    logic [7:0]        m_win, m_new;
    logic [35:0]       need;
    logic [35:0]       cap8;

    always_comb begin
        in_win = ({1'b0, b_ld_reg} >= wl_reg) && ({1'b0, b_tr_reg} >= wt_reg);
        m_win  = 8'd64 - {2'b0, wl_reg} - {1'b0, wt_reg};
        m_new  = 8'd64 - {3'b0, b_ld_reg} - {2'b0, b_tr_reg};
        if (b_dod_reg == '0) begin
            tcode = 36'b0; tlen = 8'd1;
        end else if (b_dod_reg[63:6] == '0 || b_dod_reg[63:6] == '1) begin
            tcode = {2'b10, b_dod_reg[6:0], 27'b0}; tlen = 8'd9;
        end else if (b_dod_reg[63:8] == '0 || b_dod_reg[63:8] == '1) begin
            tcode = {3'b110, b_dod_reg[8:0], 24'b0}; tlen = 8'd12;
        end else if (b_dod_reg[63:11] == '0 || b_dod_reg[63:11] == '1) begin
            tcode = {4'b1110, b_dod_reg[11:0], 20'b0}; tlen = 8'd16;
        end else begin
            tcode = {4'b1111, b_dod_reg[31:0]}; tlen = 8'd36;
        end
        if (b_xzero_reg) begin
            vcode = 77'b0; vlen = 8'd1;
        end else if (in_win) begin
            vcode = {2'b10, b_xwin_reg, 11'b0}; vlen = 8'd2 + m_win;
        end else begin
            vcode = {2'b11, b_ld_reg, m_new[5:0], b_x_reg << b_ld_reg};
            vlen  = 8'd13 + m_new;
        end
        if (first_reg) begin
            scode = {b_delta_reg[13:0], b_v_reg, 50'b0};
            slen  = 8'd78;
        end else begin
            scode = {tcode, 92'b0} | ({vcode, 51'b0} >> tlen);
            slen  = tlen + vlen;
        end
        need = {1'b0, bits_reg} + {28'b0, slen};
        cap8 = {1'b0, cfg.capacity_bytes, 3'b0};
    end

    always_comb begin
        prev_time_next  = prev_time_reg;
        prev_delta_next = prev_delta_reg;
        prev_value_next = prev_value_reg;
        wl_next         = wl_reg;
        wt_next         = wt_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        bits_next       = bits_reg;
        q_push          = 1'b0;
        q_entry         = '0;
        if (b_valid_reg && !q_full) begin
            q_push = 1'b1;
            case (b_req_reg)
                REQ_START: begin
                    prev_time_next  = cfg.block_start_time;
                    prev_delta_next = '0;
                    prev_value_next = '0;
                    wl_next         = '0;
                    wt_next         = '0;
                    first_next      = 1'b1;
                    count_next      = '0;
                    q_entry.restart = 1'b1;
                    if ({28'b0, HEADER_BITS} > cap8) begin
                        bits_next      = '0;
                        q_entry.status = ST_OVERFLOW;
                    end else begin
                        bits_next    = {27'b0, HEADER_BITS};
                        q_entry.code = {cfg.block_start_time, 64'b0};
                        q_entry.len  = HEADER_BITS;
                    end
                end
                REQ_SAMPLE: begin
                    if (first_reg && b_delta_reg > FIRST_DELTA_MAX) begin
                        q_entry.status = ST_DELTA;
                    end else if (need > cap8) begin
                        q_entry.status = ST_OVERFLOW;
                    end else begin
                        q_entry.code    = scode;
                        q_entry.len     = slen;
                        bits_next       = need[34:0];
                        count_next      = count_reg + 32'd1;
                        prev_time_next  = b_ts_reg;
                        prev_delta_next = b_delta_reg;
                        prev_value_next = b_v_reg;
                        first_next      = 1'b0;
                        if (first_reg) begin
                            wl_next = '0;
                            wt_next = '0;
                        end else if (!b_xzero_reg && !in_win) begin
                            wl_next = {1'b0, b_ld_reg};
                            wt_next = {1'b0, b_tr_reg};
                        end
                    end
                end
                REQ_FINISH: q_entry.flush = 1'b1;
                default: ;
            endcase
            q_entry.count = count_next;
            q_entry.bits  = bits_next;
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_adv) a_valid_next = 1'b0;
        if (s_valid && s_ready) a_valid_next = 1'b1;
        b_valid_next = a_adv ? 1'b1 : (q_push ? 1'b0 : b_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            prev_time_reg  <= '0;
            prev_delta_reg <= '0;
            prev_value_reg <= '0;
            wl_reg         <= '0;
            wt_reg         <= '0;
            first_reg      <= 1'b1;
            count_reg      <= '0;
            bits_reg       <= '0;
        end else begin
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            prev_time_reg  <= prev_time_next;
            prev_delta_reg <= prev_delta_next;
            prev_value_reg <= prev_value_next;
            wl_reg         <= wl_next;
            wt_reg         <= wt_next;
            first_reg      <= first_next;
            count_reg      <= count_next;
            bits_reg       <= bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) a_reg <= s_data;
        if (a_adv) begin
            b_req_reg   <= a_reg.req_type;
            b_ts_reg    <= a_reg.timestamp;
            b_v_reg     <= a_reg.value_bits;
            b_delta_reg <= a_reg.timestamp - prev_time_reg;
            b_dod_reg   <= a_reg.timestamp - prev_time_reg - prev_delta_reg;
            b_x_reg     <= x_a;
            b_xzero_reg <= (x_a == '0);
            b_ld_reg    <= lz_a[5] ? 5'd31 : lz_a[4:0];
            b_tr_reg    <= tz_a;
            b_xwin_reg  <= x_a << wl_reg;
        end
    end

endmodule

>>> rtl/tsdx_queue.sv
`timescale 1ns / 1ps
module tsdx_queue
    import tsdx_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_data;
    end

endmodule

>>> rtl/tsdx_back.sv
`timescale 1ns / 1ps
module tsdx_back
    import tsdx_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  entry_t    q_entry,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [63:0] pack_word_reg;
    logic [5:0]  pack_fill_reg;
    out_item_t   out_reg, pend_reg;
    logic        out_valid_reg, pend_valid_reg;

    logic [63:0]  base_word;
    logic [5:0]   base_fill;
    logic [191:0] wide;
    logic [7:0]   total;
    logic [1:0]   nw;
    out_item_t    r0, r1;
    logic [63:0]  rest;

    assign q_pop   = q_valid && (!out_valid_reg || (m_ready && !pend_valid_reg));
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        base_word = q_entry.restart ? 64'b0 : pack_word_reg;
        base_fill = q_entry.restart ? 6'b0 : pack_fill_reg;
        wide  = {base_word, 128'b0} | ({q_entry.code, 64'b0} >> base_fill);
        total = {2'b0, base_fill} + q_entry.len;
        nw    = total[7:6];
        r0             = '0;
        r0.status      = q_entry.status;
        r0.point_count = q_entry.count;
        r0.bit_length  = q_entry.bits;
        r1             = r0;
        r1.out_word    = wide[127:64];
        r1.word_valid  = 1'b1;
        r1.last        = 1'b1;
        case (nw)
            2'd0:    rest = wide[191:128];
            2'd1:    rest = wide[127:64];
            default: rest = wide[63:0];
        endcase
        if (q_entry.flush) begin
            // pending bits already zero padded
            r0.word_valid = (pack_fill_reg != '0);
            r0.out_word   = r0.word_valid ? pack_word_reg : 64'b0;
            r0.last       = 1'b1;
            r0.status     = ST_OK;
        end else if (nw != 2'd0) begin
            r0.out_word   = wide[191:128];
            r0.word_valid = 1'b1;
            r0.last       = (nw == 2'd1);
        end else begin
            r0.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pack_word_reg  <= '0;
            pack_fill_reg  <= '0;
        end else begin
            if (q_pop) begin
                out_valid_reg  <= 1'b1;
                out_reg        <= r0;
                pend_reg       <= r1;
                pend_valid_reg <= !q_entry.flush && (nw == 2'd2);
                if (q_entry.flush) begin
                    pack_word_reg <= '0;
                    pack_fill_reg <= '0;
                end else begin
                    pack_word_reg <= rest;
                    pack_fill_reg <= total[5:0];
                end
            end else if (out_valid_reg && m_ready) begin
                if (pend_valid_reg) begin
                    out_reg        <= pend_reg;
                    pend_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    a_pend_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("second word pending without a first");

    a_pend_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !out_reg.last)
        else $error("first of two words marked last");

    a_empty_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.word_valid) |-> (out_reg.out_word == '0 && out_reg.last))
        else $error("word-less result carries bits");

    a_pend_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && m_ready) |=> (out_valid_reg && out_reg.last))
        else $error("second word lost");

endmodule
